>>> rtl/twts_pkg.sv
`default_nettype none
package twts_pkg;

	localparam int VALUE_BITS = 16;
	localparam int ACC_BITS   = 22;
	localparam int TAU_BITS   = 16;
	localparam int ROUND_Q15  = 16384;

	localparam logic [1:0] MODE_PASS = 2'd0;
	localparam logic [1:0] MODE_AVG  = 2'd1;
	localparam logic [1:0] MODE_PROD = 2'd2;

	localparam logic [2:0] CFG_MODE        = 3'd0;
	localparam logic [2:0] CFG_HALF_WINDOW = 3'd1;
	localparam logic [2:0] CFG_THRESHOLD   = 3'd2;
	localparam logic [2:0] CFG_TAU         = 3'd3;
	localparam logic [2:0] CFG_BG_MASK     = 3'd4;
	localparam logic [2:0] CFG_TOPIC_COUNT = 3'd5;

	// window offset updates
	localparam logic [2:0] D_HOLD   = 3'd0;
	localparam logic [2:0] D_ZERO   = 3'd1;
	localparam logic [2:0] D_NEG_H  = 3'd2;
	localparam logic [2:0] D_INC    = 3'd3;
	localparam logic [2:0] D_PLUS1  = 3'd4;
	localparam logic [2:0] D_MINUS1 = 3'd5;

	typedef struct packed {
		logic               action;
		logic [15:0]        prob_value;
		logic               doc_start;
	} twts_in_t;

	typedef struct packed {
		logic signed [31:0] smoothed_value;
		logic [15:0]        row_index;
		logic [5:0]         topic_index;
		logic               doc_last;
	} twts_out_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [3:0]         half_window;
		logic [21:0]        threshold;
		logic signed [15:0] tau;
		logic [63:0]        background_topic_mask;
		logic [6:0]         topic_count;
	} twts_cfg_t;

	typedef struct packed {
		logic       capture;
		logic       start;
		logic       push;
		logic       rd;
		logic [2:0] dsel;
		logic       set_last;
		logic       last_val;
		logic       sum_clr;
		logic       tap_latch;
		logic       sum_acc;
		logic       mul1;
		logic       fin1;
		logic       v_load_p;
		logic       mul2;
		logic       sh2;
		logic       emit;
	} twts_cmd_t;

	typedef struct packed {
		logic       emit_due;
		logic       pend_zero;
		logic       pend_one;
		logic [1:0] mode;
		logic       tap_ok;
		logic       tap_bg;
		logic       d_end;
		logic       h_zero;
		logic       j_ge1;
		logic       out_free;
	} twts_sts_t;

endpackage
`default_nettype wire

>>> rtl/token_window_topic_smoother.sv
`default_nettype none
// Smooths a token-by-topic probability matrix streamed row-major, one element per
// transfer, and returns each element max(h,1) rows later through a one-deep
// output register; drain transfers flush the tail one element each. Items are
// handled one at a time by a sequencer around a single-ported line buffer of
// 2*MAX_HALF_WINDOW+1 rows: a push writes its element and, once one is due, reads
// back the oldest pending element; pass-through mode and background rows in
// moving-average mode return it unchanged, moving-average mode reads the window
// rows one by one and moving-product mode makes two neighbour reads, each
// multiplied and rounded. A push that starts a document first restarts the window,
// a drain emits like a push and one with nothing pending emits nothing. An
// emitting item also waits while the previous result is still held by a stall.
// The block takes the next item while an emitted result still waits for its
// transfer. half_window and topic_count are sampled at each document start; the
// other registers act at once.
module token_window_topic_smoother import twts_pkg::*; #(
	parameter int MAX_TOPICS      = 64,
	parameter int MAX_HALF_WINDOW = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire twts_in_t    item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output twts_out_t        result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	twts_cfg_t cfg_q;
	twts_cmd_t cmd;
	twts_sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode                  <= MODE_PASS;
			cfg_q.half_window           <= 4'd1;
			cfg_q.threshold             <= 22'd16384;
			cfg_q.tau                   <= 16'sd256;
			cfg_q.background_topic_mask <= '0;
			cfg_q.topic_count           <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:        cfg_q.mode                  <= cfg_data[1:0];
				CFG_HALF_WINDOW: cfg_q.half_window           <= cfg_data[3:0];
				CFG_THRESHOLD:   cfg_q.threshold             <= cfg_data[21:0];
				CFG_TAU:         cfg_q.tau                   <= cfg_data[15:0];
				CFG_BG_MASK:     cfg_q.background_topic_mask <= cfg_data;
				CFG_TOPIC_COUNT: cfg_q.topic_count           <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	twts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.sts        (sts),
		.cmd        (cmd)
	);

	twts_datapath #(
		.MAX_TOPICS      (MAX_TOPICS),
		.MAX_HALF_WINDOW (MAX_HALF_WINDOW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

>>> rtl/twts_ctrl.sv
`default_nettype none
module twts_ctrl import twts_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_stall,
	input  wire twts_in_t  item,
	input  wire twts_sts_t sts,
	output twts_cmd_t      cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_START = 5'd1;
	localparam logic [4:0] S_WRITE = 5'd2;
	localparam logic [4:0] S_CHECK = 5'd3;
	localparam logic [4:0] S_DCHK  = 5'd4;
	localparam logic [4:0] S_RDP   = 5'd5;
	localparam logic [4:0] S_GOTP  = 5'd6;
	localparam logic [4:0] S_WRD   = 5'd7;
	localparam logic [4:0] S_WGOT  = 5'd8;
	localparam logic [4:0] S_MUL   = 5'd9;
	localparam logic [4:0] S_FIN   = 5'd10;
	localparam logic [4:0] S_NCHK  = 5'd11;
	localparam logic [4:0] S_NRD   = 5'd12;
	localparam logic [4:0] S_NGOT  = 5'd13;
	localparam logic [4:0] S_NSH   = 5'd14;
	localparam logic [4:0] S_PCHK  = 5'd15;
	localparam logic [4:0] S_PRD   = 5'd16;
	localparam logic [4:0] S_PGOT  = 5'd17;
	localparam logic [4:0] S_PSH   = 5'd18;
	localparam logic [4:0] S_OUT   = 5'd19;

	logic [4:0] state_q;
	logic [4:0] state_n;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					if (item.action)
						state_n = S_DCHK;
					else if (item.doc_start)
						state_n = S_START;
					else
						state_n = S_WRITE;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_n   = S_WRITE;
			end
			S_WRITE: begin
				cmd.push = 1'b1;
				state_n  = S_CHECK;
			end
			S_CHECK: begin
				if (sts.emit_due) begin
					cmd.set_last = 1'b1;
					cmd.dsel     = D_ZERO;
					state_n      = S_RDP;
				end else begin
					state_n = S_IDLE;
				end
			end
			S_DCHK: begin
				if (sts.pend_zero) begin
					state_n = S_IDLE;
				end else begin
					cmd.set_last = 1'b1;
					cmd.last_val = sts.pend_one;
					cmd.dsel     = D_ZERO;
					state_n      = S_RDP;
				end
			end
			S_RDP: begin
				cmd.rd  = 1'b1;
				state_n = S_GOTP;
			end
			S_GOTP: begin
				cmd.v_load_p = 1'b1;
				cmd.sum_clr  = 1'b1;
				if (sts.mode == MODE_AVG && !sts.tap_bg) begin
					if (sts.h_zero) begin
						state_n = S_MUL;
					end else begin
						cmd.dsel = D_NEG_H;
						state_n  = S_WRD;
					end
				end else if (sts.mode == MODE_PROD) begin
					cmd.dsel = D_PLUS1;
					state_n  = S_NCHK;
				end else begin
					state_n = S_OUT;
				end
			end
			S_WRD: begin
				cmd.rd        = 1'b1;
				cmd.tap_latch = 1'b1;
				state_n       = S_WGOT;
			end
			S_WGOT: begin
				cmd.sum_acc = 1'b1;
				if (sts.d_end) begin
					state_n = S_MUL;
				end else begin
					cmd.dsel = D_INC;
					state_n  = S_WRD;
				end
			end
			S_MUL: begin
				cmd.mul1 = 1'b1;
				state_n  = S_FIN;
			end
			S_FIN: begin
				cmd.fin1 = 1'b1;
				state_n  = S_OUT;
			end
			S_NCHK: begin
				if (sts.tap_ok) begin
					state_n = S_NRD;
				end else begin
					cmd.dsel = D_MINUS1;
					state_n  = S_PCHK;
				end
			end
			S_NRD: begin
				cmd.rd  = 1'b1;
				state_n = S_NGOT;
			end
			S_NGOT: begin
				cmd.mul2 = 1'b1;
				state_n  = S_NSH;
			end
			S_NSH: begin
				cmd.sh2  = 1'b1;
				cmd.dsel = D_MINUS1;
				state_n  = S_PCHK;
			end
			S_PCHK: begin
				state_n = sts.j_ge1 ? S_PRD : S_OUT;
			end
			S_PRD: begin
				cmd.rd  = 1'b1;
				state_n = S_PGOT;
			end
			S_PGOT: begin
				cmd.mul2 = 1'b1;
				state_n  = S_PSH;
			end
			S_PSH: begin
				cmd.sh2 = 1'b1;
				state_n = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

endmodule
`default_nettype wire

>>> rtl/twts_datapath.sv
`default_nettype none
module twts_datapath import twts_pkg::*; #(
	parameter int MAX_TOPICS      = 64,
	parameter int MAX_HALF_WINDOW = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire twts_cfg_t cfg,
	input  wire twts_in_t  item,
	input  wire twts_cmd_t cmd,
	output twts_sts_t      sts,
	output logic           result_valid,
	input  wire logic      result_stall,
	output twts_out_t      result
);

	localparam int RING  = 2 * MAX_HALF_WINDOW + 1;
	localparam int SLW   = $clog2(RING);
	localparam int TW    = (MAX_TOPICS > 1) ? $clog2(MAX_TOPICS) : 1;
	localparam int TCW   = $clog2(MAX_TOPICS + 1);
	localparam int HW    = $clog2(MAX_HALF_WINDOW + 1);
	localparam int DW    = HW + 1;
	localparam int AHW   = $clog2(MAX_HALF_WINDOW + 3);
	localparam int LW    = $clog2(MAX_HALF_WINDOW * MAX_TOPICS + 2);
	localparam int DEPTH = RING * MAX_TOPICS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = VALUE_BITS + $clog2(2 * MAX_HALF_WINDOW + 1);
	localparam int PW    = SW + TAU_BITS + 1;
	localparam int P2W   = 2 * VALUE_BITS + 1;
	localparam int TSW   = SLW + DW + 1;
	localparam int RST_T = (MAX_TOPICS < 64) ? MAX_TOPICS : 64;

	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [VALUE_BITS-1:0] rdata_q;

	logic [SLW-1:0]        in_slot_q;
	logic [TW-1:0]         in_topic_q;
	logic [SLW-1:0]        out_slot_q;
	logic [TW-1:0]         out_topic_q;
	logic [15:0]           out_row_q;
	logic [AHW-1:0]        ahead_q;
	logic [LW-1:0]         pend_q;
	logic [LW-1:0]         limit_q;
	logic [HW-1:0]         lat_h_q;
	logic [TCW-1:0]        lat_t_q;
	logic [ACC_BITS-1:0]   acc_q;
	logic [RING-1:0]       bg_flags_q;
	logic signed [DW-1:0]  d_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  last_q;
	logic                  tap_use_q;
	logic [SW-1:0]         sum_q;
	logic [VALUE_BITS-1:0] p_q;
	logic [31:0]           v_q;
	logic signed [PW-1:0]  prod1_q;
	logic [P2W-1:0]        prod2_q;
	twts_out_t             res_q;
	logic                  res_valid_q;

	logic signed [TSW-1:0] tap_sum;
	logic signed [TSW-1:0] tap_fix;
	logic [SLW-1:0]        tap_slot;
	int                    d_int;
	logic                  tap_ok;
	logic                  tap_bg;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic                  topic_bg;
	logic [ACC_BITS-1:0]   acc_next;
	logic                  in_wrap;
	logic                  out_wrap;
	logic                  out_free;
	int                    hs_i;
	int                    ts_i;
	int                    lim_i;
	logic signed [63:0]    ext;
	logic signed [63:0]    rnd;
	logic signed [63:0]    tot;
	logic [31:0]           sat_val;
	logic [P2W:0]          sh_tmp;

	// ring slot of row j+d
	always_comb begin
		d_int   = int'(d_q);
		tap_sum = TSW'(signed'({1'b0, out_slot_q})) + TSW'(d_q);
		if (tap_sum < 0)
			tap_fix = tap_sum + TSW'(RING);
		else if (tap_sum >= TSW'(RING))
			tap_fix = tap_sum - TSW'(RING);
		else
			tap_fix = tap_sum;
		tap_slot = SLW'(tap_fix);
		if (d_int < 0)
			tap_ok = int'(out_row_q) >= -d_int;
		else
			tap_ok = (d_int < int'(ahead_q)) ||
			         (d_int == int'(ahead_q) && out_topic_q < in_topic_q);
		// the row still being received is judged on its partial sum
		if (d_int < int'(ahead_q))
			tap_bg = bg_flags_q[tap_slot];
		else
			tap_bg = acc_q > cfg.threshold;
	end

	assign rd_addr  = AW'(int'(tap_slot) * MAX_TOPICS + int'(out_topic_q));
	assign wr_addr  = AW'(int'(in_slot_q) * MAX_TOPICS + int'(in_topic_q));
	assign topic_bg = (int'(in_topic_q) < 64) && cfg.background_topic_mask[6'(in_topic_q)];
	assign acc_next = acc_q + (topic_bg ? ACC_BITS'(value_q) : '0);
	assign in_wrap  = int'(in_topic_q) + 1 >= int'(lat_t_q);
	assign out_wrap = int'(out_topic_q) + 1 >= int'(lat_t_q);
	assign out_free = !res_valid_q || !result_stall;

	always_comb begin
		hs_i = (int'(cfg.half_window) > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW
		                                                  : int'(cfg.half_window);
		if (cfg.topic_count == '0)
			ts_i = 1;
		else if (int'(cfg.topic_count) > MAX_TOPICS)
			ts_i = MAX_TOPICS;
		else
			ts_i = int'(cfg.topic_count);
		lim_i = ((hs_i == 0) ? 1 : hs_i) * ts_i;
	end

	// tau * sum in Q.23, round to nearest (half up) to Q.15, add element, saturate
	always_comb begin
		ext = 64'(prod1_q);
		rnd = (ext + 64'sd128) >>> 8;
		tot = rnd + 64'(signed'({1'b0, p_q}));
		if (tot > 64'sd2147483647)
			sat_val = 32'h7fff_ffff;
		else if (tot < -64'sd2147483648)
			sat_val = 32'h8000_0000;
		else
			sat_val = tot[31:0];
		sh_tmp = (P2W + 1)'(prod2_q) + (P2W + 1)'(ROUND_Q15);
	end

	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[wr_addr] <= value_q;
		if (cmd.rd)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			value_q <= VALUE_BITS'(item.prob_value);
		if (cmd.set_last)
			last_q <= cmd.last_val;
		if (cmd.tap_latch)
			tap_use_q <= tap_ok && !tap_bg;
		if (cmd.sum_clr)
			sum_q <= '0;
		else if (cmd.sum_acc && tap_use_q)
			sum_q <= sum_q + SW'(rdata_q);
		if (cmd.v_load_p) begin
			p_q <= rdata_q;
			v_q <= 32'(rdata_q);
		end else if (cmd.fin1) begin
			v_q <= sat_val;
		end else if (cmd.sh2) begin
			v_q <= 32'(sh_tmp >> 15);
		end
		if (cmd.mul1)
			prod1_q <= PW'(cfg.tau) * PW'(signed'({1'b0, sum_q}));
		if (cmd.mul2)
			prod2_q <= P2W'(v_q[VALUE_BITS:0]) * P2W'(rdata_q);
		if (cmd.emit)
			res_q <= '{smoothed_value: v_q, row_index: out_row_q,
			           topic_index: 6'(out_topic_q), doc_last: last_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_slot_q   <= '0;
			in_topic_q  <= '0;
			out_slot_q  <= '0;
			out_topic_q <= '0;
			out_row_q   <= '0;
			ahead_q     <= '0;
			pend_q      <= '0;
			limit_q     <= LW'(RST_T);
			lat_h_q     <= HW'(1);
			lat_t_q     <= TCW'(RST_T);
			acc_q       <= '0;
			bg_flags_q  <= '0;
			d_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				in_slot_q   <= '0;
				in_topic_q  <= '0;
				out_slot_q  <= '0;
				out_topic_q <= '0;
				out_row_q   <= '0;
				ahead_q     <= '0;
				pend_q      <= '0;
				acc_q       <= '0;
				lat_h_q     <= HW'(hs_i);
				lat_t_q     <= TCW'(ts_i);
				limit_q     <= LW'(lim_i);
			end
			if (cmd.push) begin
				pend_q <= pend_q + 1'b1;
				if (in_wrap) begin
					bg_flags_q[in_slot_q] <= acc_next > cfg.threshold;
					acc_q      <= '0;
					in_topic_q <= '0;
					in_slot_q  <= (in_slot_q == SLW'(RING - 1)) ? '0 : in_slot_q + 1'b1;
					ahead_q    <= ahead_q + 1'b1;
				end else begin
					acc_q      <= acc_next;
					in_topic_q <= in_topic_q + 1'b1;
				end
			end
			unique case (cmd.dsel)
				D_HOLD:   d_q <= d_q;
				D_ZERO:   d_q <= '0;
				D_NEG_H:  d_q <= DW'(-int'(lat_h_q));
				D_INC:    d_q <= d_q + DW'(1);
				D_PLUS1:  d_q <= DW'(1);
				D_MINUS1: d_q <= DW'(-1);
				default:  d_q <= d_q;
			endcase
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
				pend_q      <= pend_q - 1'b1;
				if (out_wrap) begin
					out_topic_q <= '0;
					out_slot_q  <= (out_slot_q == SLW'(RING - 1)) ? '0 : out_slot_q + 1'b1;
					ahead_q     <= ahead_q - 1'b1;
					if (out_row_q != 16'hffff)
						out_row_q <= out_row_q + 1'b1;
				end else begin
					out_topic_q <= out_topic_q + 1'b1;
				end
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign sts = '{emit_due:  pend_q > limit_q,
	               pend_zero: pend_q == '0,
	               pend_one:  pend_q == LW'(1),
	               mode:      cfg.mode,
	               tap_ok:    tap_ok,
	               tap_bg:    tap_bg,
	               d_end:     d_int == int'(lat_h_q) - 1,
	               h_zero:    lat_h_q == '0,
	               j_ge1:     out_row_q != '0,
	               out_free:  out_free};

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(LW + 1)'(pend_q) <= (LW + 1)'(limit_q) + 1'b1)
		else $error("pending count beyond emit limit");

	a_ahead_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(ahead_q) <= MAX_HALF_WINDOW + 1)
		else $error("input row lead exceeds line buffer");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result overwritten before transfer");

	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> pend_q != '0)
		else $error("emit with nothing pending");

	a_topic_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_topic_q < TW'(lat_t_q) || int'(lat_t_q) > (1 << TW) - 1)
		else $error("output topic beyond row length");

endmodule
`default_nettype wire
